>>> hw/rtl/tns_pkg.sv
`default_nettype none
package tns_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int FREQ_W = 15;
  localparam int DUR_W  = 16;
  localparam int REP_W  = 8;
  localparam int GAP_W  = 16;
  localparam int LVL_W  = 5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // Operation codes carried in tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Stored note; lead counts the phase-less notes queued just ahead of it
  typedef struct packed {
    logic [CNT_W-1:0]  lead;
    logic [GAP_W-1:0]  gap;
    logic [REP_W-1:0]  rep;
    logic [DUR_W-1:0]  dur;
    logic [FREQ_W-1:0] freq;
  } qent_t;

  // A note that has no phase of nonzero length and ends without a tick
  function automatic logic note_is_empty(input logic [FREQ_W-1:0] freq,
                                         input logic [DUR_W-1:0]  dur,
                                         input logic [REP_W-1:0]  rep,
                                         input logic [GAP_W-1:0]  gap);
    note_is_empty = (dur == '0) &&
                    ((freq == '0) || (rep <= REP_W'(1)) || (gap == '0));
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tone_note_sequencer.sv
`default_nettype none
// A result beat is registered in the output register, or in the skid stage while
// out_* stalls. Throughput: one beat per cycle while in_tready is high; the output
// register plus a one-beat skid stage keep in_tready high while a single result
// waits, so a stall on out_* costs nothing until both registers hold a result.
// Reset (rst_n low, synchronous): note queue empty, player idle, no result pending.
// Queue storage is not cleared; only written entries are ever read.
module tone_note_sequencer
  import tns_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [14:0] note_frequency, [30:15] note_duration_ms, [38:31] note_repeats,
  // [54:39] note_gap_ms, [55] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] operation
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [14:0] tone_frequency, [15] tone_on, [16] busy_res, [17] push_rejected,
  // [22:18] queue_level, [23] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TONE   = 2'd1,
    PH_SILENT = 2'd2,
    PH_GAP    = 2'd3
  } phase_t;

  // Input beat fields
  logic [FREQ_W-1:0] in_freq;
  logic [DUR_W-1:0]  in_dur;
  logic [REP_W-1:0]  in_rep;
  logic [GAP_W-1:0]  in_gap;
  logic              in_fire;
  logic              out_fire;

  assign in_freq = in_tdata[14:0];
  assign in_dur  = in_tdata[30:15];
  assign in_rep  = in_tdata[38:31];
  assign in_gap  = in_tdata[54:39];

  // Queue: only notes with playable phases are stored. Phase-less notes are
  // counted in front of the next stored note (lead) or at the tail (trail).
  qent_t            q_mem_r [QUEUE_DEPTH];
  qent_t            head_ent;
  logic             q_wr_en;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] real_cnt_r, real_cnt_nxt;    // stored entries
  logic [CNT_W-1:0] total_cnt_r, total_cnt_nxt;  // notes waiting, as reported
  logic [CNT_W-1:0] trail_r, trail_nxt;          // phase-less notes after last stored

  // Player
  phase_t            phase_r, phase_nxt;
  logic [DUR_W-1:0]  ticks_r, ticks_nxt;
  logic [REP_W-1:0]  reps_r, reps_nxt;
  logic [FREQ_W-1:0] cur_freq_r, cur_freq_nxt;
  logic [DUR_W-1:0]  cur_dur_r, cur_dur_nxt;
  logic [GAP_W-1:0]  cur_gap_r, cur_gap_nxt;

  // Result
  logic [FREQ_W-1:0]     res_freq;
  logic                  res_on;
  logic                  res_busy;
  logic                  res_rej;
  logic [OUT_DATA_W-1:0] res_data;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  skid_valid_r;
  logic [OUT_DATA_W-1:0] skid_data_r;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign head_ent = q_mem_r[head_r];

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    real_cnt_nxt  = real_cnt_r;
    total_cnt_nxt = total_cnt_r;
    trail_nxt     = trail_r;
    phase_nxt     = phase_r;
    ticks_nxt     = ticks_r;
    reps_nxt      = reps_r;
    cur_freq_nxt  = cur_freq_r;
    cur_dur_nxt   = cur_dur_r;
    cur_gap_nxt   = cur_gap_r;
    q_wr_en       = 1'b0;
    res_freq      = '0;
    res_on        = 1'b0;
    res_rej       = 1'b0;

    if (in_fire) begin
      if (in_tuser == OP_PUSH) begin
        if (total_cnt_r >= CNT_W'(QUEUE_DEPTH)) begin
          res_rej = 1'b1;
        end else begin
          total_cnt_nxt = total_cnt_r + CNT_W'(1);
          if (note_is_empty(in_freq, in_dur, in_rep, in_gap)) begin
            trail_nxt = trail_r + CNT_W'(1);
          end else begin
            q_wr_en      = 1'b1;
            trail_nxt    = '0;
            real_cnt_nxt = real_cnt_r + CNT_W'(1);
            tail_nxt     = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
          end
        end
      end else begin
        // Idle: pop the phase-less notes ahead and the next playable note, or the trailing ones
        if (phase_r == PH_IDLE) begin
          if (real_cnt_r != '0) begin
            total_cnt_nxt = total_cnt_r - head_ent.lead - CNT_W'(1);
            real_cnt_nxt  = real_cnt_r - CNT_W'(1);
            head_nxt      = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
            cur_freq_nxt  = head_ent.freq;
            cur_dur_nxt   = head_ent.dur;
            cur_gap_nxt   = head_ent.gap;
            if (head_ent.freq == '0) begin
              phase_nxt = PH_SILENT;
              ticks_nxt = head_ent.dur;
              reps_nxt  = '0;
            end else if (head_ent.dur != '0) begin
              phase_nxt = PH_TONE;
              ticks_nxt = head_ent.dur;
              reps_nxt  = (head_ent.rep == '0) ? REP_W'(1) : head_ent.rep;
            end else begin
              // Zero-length tone: go straight to the first gap
              phase_nxt = PH_GAP;
              ticks_nxt = head_ent.gap;
              reps_nxt  = head_ent.rep - REP_W'(1);
            end
          end else begin
            total_cnt_nxt = '0;
            trail_nxt     = '0;
          end
        end

        // Play one millisecond, then skip any phases left with no time
        if (phase_nxt != PH_IDLE) begin
          if (phase_nxt == PH_TONE) begin
            res_freq = cur_freq_nxt;
            res_on   = 1'b1;
          end
          ticks_nxt = ticks_nxt - DUR_W'(1);
          if (ticks_nxt == '0) begin
            unique case (phase_nxt)
              PH_TONE: begin
                reps_nxt = reps_nxt - REP_W'(1);
                if (reps_nxt == '0) begin
                  phase_nxt = PH_IDLE;
                end else if (cur_gap_nxt != '0) begin
                  phase_nxt = PH_GAP;
                  ticks_nxt = cur_gap_nxt;
                end else begin
                  ticks_nxt = cur_dur_nxt;
                end
              end
              PH_GAP: begin
                if (cur_dur_nxt != '0) begin
                  phase_nxt = PH_TONE;
                  ticks_nxt = cur_dur_nxt;
                end else begin
                  reps_nxt = reps_nxt - REP_W'(1);
                  if (reps_nxt == '0) begin
                    phase_nxt = PH_IDLE;
                  end else begin
                    ticks_nxt = cur_gap_nxt;
                  end
                end
              end
              PH_SILENT: begin
                phase_nxt = PH_IDLE;
              end
              PH_IDLE: begin
              end
            endcase
          end
        end
      end
    end

    res_busy = (phase_nxt != PH_IDLE) || (total_cnt_nxt != '0);
    res_data = {1'b0, LVL_W'(total_cnt_nxt), res_rej, res_busy, res_on, res_freq};
  end

  // Queue storage: write at tail, no reset
  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      q_mem_r[tail_r] <= '{lead: trail_r, gap: in_gap, rep: in_rep,
                           dur: in_dur, freq: in_freq};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      real_cnt_r   <= '0;
      total_cnt_r  <= '0;
      trail_r      <= '0;
      phase_r      <= PH_IDLE;
      ticks_r      <= '0;
      reps_r       <= '0;
      cur_freq_r   <= '0;
      cur_dur_r    <= '0;
      cur_gap_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      real_cnt_r  <= real_cnt_nxt;
      total_cnt_r <= total_cnt_nxt;
      trail_r     <= trail_nxt;
      phase_r     <= phase_nxt;
      ticks_r     <= ticks_nxt;
      reps_r      <= reps_nxt;
      cur_freq_r  <= cur_freq_nxt;
      cur_dur_r   <= cur_dur_nxt;
      cur_gap_r   <= cur_gap_nxt;

      // Drain the skid beat first; otherwise land new results in the output
      // register, or hold them in the skid stage while the output stalls
      if (skid_valid_r) begin
        if (out_fire) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_valid_r && !out_tready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of output and skid registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_data_r <= res_data;
      end else begin
        out_data_r <= res_data;
      end
    end
  end

endmodule
`default_nettype wire
